/* rtl/ptw_pkg.sv */
// Shared types and constants for the two-level page table walker.
package ptw_pkg;

   localparam int unsigned WORD_W = 32;

   localparam logic [1:0] KIND_SECTION = 2'd0;
   localparam logic [1:0] KIND_LARGE   = 2'd1;
   localparam logic [1:0] KIND_SMALL   = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam logic [1:0] L1_FAULT   = 2'b00;
   localparam logic [1:0] L1_COARSE  = 2'b01;
   localparam logic [1:0] L1_SECTION = 2'b10;
   localparam logic [1:0] L1_FINE    = 2'b11;
   localparam logic [1:0] L2_LARGE   = 2'b01;
   localparam logic [1:0] L2_SMALL   = 2'b10;

   localparam logic OP_WRITE     = 1'b0;
   localparam logic OP_TRANSLATE = 1'b1;

   typedef struct packed {
      logic clear_en;
      logic wr_en;
      logic rd_first;
      logic rd_second;
      logic rsp_load;
      logic rsp_from_second;
   } ptw_cmd_type;

   typedef struct packed {
      logic first_coarse;
      logic clear_last;
   } ptw_sts_type;

endpackage

/* rtl/ptw_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module ptw_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/ptw_dp.sv */
// Walker datapath: table base, descriptor store, address forming and result decode.
module ptw_dp import ptw_pkg::*; #(
   parameter int unsigned DESC_WORDS = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [31:0]       csr_write_data,
   input  logic [12:0]       req_word_index,
   input  logic [31:0]       req_descriptor,
   input  logic [31:0]       req_virtual_address,
   input  ptw_cmd_type       cmd,
   output ptw_sts_type       sts,
   output logic [31:0]       rsp_physical_address,
   output logic [1:0]        rsp_mapping_kind
);

   localparam int unsigned AW = $clog2(DESC_WORDS);

   logic [31:0]       table_base_ff, table_base_in;
   logic [AW-1:0]     clear_cnt_ff, clear_cnt_in;
   logic [19:0]       va_ff;
   logic [31:0]       pa_ff, pa_in;
   logic [1:0]        kind_ff, kind_in;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [WORD_W-1:0] ram_rdata;
   logic [29:0]       first_word_addr;
   logic [29:0]       second_word_addr;

   assign table_base_in = csr_write_enable ? csr_write_data : table_base_ff;
   assign clear_cnt_in  = cmd.clear_en ? clear_cnt_ff + AW'(1) : clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff <= '0;
         clear_cnt_ff  <= '0;
      end else begin
         table_base_ff <= table_base_in;
         clear_cnt_ff  <= clear_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_first) begin
         va_ff <= req_virtual_address[19:0];
      end
      if (cmd.rsp_load) begin
         pa_ff   <= pa_in;
         kind_ff <= kind_in;
      end
   end

   // word addresses: table bases are aligned, so the offsets never carry
   assign first_word_addr  = {table_base_ff[31:14], req_virtual_address[31:20]};
   assign second_word_addr = {ram_rdata[31:10], va_ff[19:12]};

   assign ram_we    = cmd.clear_en | cmd.wr_en;
   assign ram_waddr = cmd.clear_en ? clear_cnt_ff : AW'(req_word_index);
   assign ram_wdata = cmd.clear_en ? '0 : req_descriptor;
   assign ram_re    = cmd.rd_first | cmd.rd_second;
   assign ram_raddr = cmd.rd_second ? AW'(second_word_addr) : AW'(first_word_addr);

   ptw_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DESC_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      pa_in   = '0;
      kind_in = KIND_NONE;
      if (!cmd.rsp_from_second) begin
         if (ram_rdata[1:0] == L1_SECTION) begin
            pa_in   = {ram_rdata[31:20], va_ff[19:0]};
            kind_in = KIND_SECTION;
         end
      end else begin
         priority if (ram_rdata[1:0] == L2_LARGE) begin
            pa_in   = {ram_rdata[31:16], va_ff[15:0]};
            kind_in = KIND_LARGE;
         end else if (ram_rdata[1:0] == L2_SMALL) begin
            pa_in   = {ram_rdata[31:12], va_ff[11:0]};
            kind_in = KIND_SMALL;
         end else begin
            pa_in   = '0;
            kind_in = KIND_NONE;
         end
      end
   end

   assign sts.first_coarse = (ram_rdata[1:0] == L1_COARSE);
   assign sts.clear_last   = (clear_cnt_ff == AW'(DESC_WORDS - 1));

   assign rsp_physical_address = pa_ff;
   assign rsp_mapping_kind     = kind_ff;

endmodule

/* rtl/ptw_ctrl.sv */
// Walker controller: store clear pass, item acceptance, walk sequencing, result valid.
module ptw_ctrl import ptw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_operation,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  ptw_sts_type sts,
   output ptw_cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_FIRST  = 2'd2;
   localparam logic [1:0] ST_SECOND = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign slot_free = ~rsp_valid_ff | ~rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_WRITE) begin
                  cmd.wr_en = 1'b1;
               end else begin
                  cmd.rd_first = 1'b1;
                  state_in     = ST_FIRST;
               end
            end
         end
         ST_FIRST: begin
            if (sts.first_coarse) begin
               cmd.rd_second = 1'b1;
               state_in      = ST_SECOND;
            end else if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SECOND: begin
            cmd.rsp_from_second = 1'b1;
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/two_level_page_table_walker_core.sv */
// Top level of the two-level page table walker: controller, datapath and checks.
//
//   beat      | direction | fields
//   req_      | in        | operation, word_index, descriptor, virtual_address
//   rsp_      | out       | physical_address, mapping_kind
//   csr_      | in        | write_data (table_base), write_enable
//
// A write beat is taken in ST_IDLE and the walker stays idle. A translate beat passes ST_FIRST for a
// section or fault, and ST_FIRST then ST_SECOND for a coarse walk: each descriptor read is one registered store read.
// After reset the store is zeroed one word per cycle, all DESC_WORDS words, with
// req_stall high; table_base writes are taken throughout.
// A stalled result holds in the output register; a following walk then waits in its
// last read state while further requests stay stalled.
// DESC_WORDS must be a power of two.
module two_level_page_table_walker_core import ptw_pkg::*; #(
   parameter int unsigned DESC_WORDS = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_operation,
   input  logic [12:0] req_word_index,
   input  logic [31:0] req_descriptor,
   input  logic [31:0] req_virtual_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_physical_address,
   output logic [1:0]  rsp_mapping_kind
);

   ptw_cmd_type cmd;
   ptw_sts_type sts;

   ptw_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   ptw_dp #(
      .DESC_WORDS (DESC_WORDS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_word_index       (req_word_index),
      .req_descriptor       (req_descriptor),
      .req_virtual_address  (req_virtual_address),
      .cmd                  (cmd),
      .sts                  (sts),
      .rsp_physical_address (rsp_physical_address),
      .rsp_mapping_kind     (rsp_mapping_kind)
   );

   a_stall_after_reset: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> req_stall)
      else $error("request taken during store clear");

   a_no_map_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mapping_kind == KIND_NONE) |-> rsp_physical_address == 32'd0)
      else $error("no-mapping result with nonzero address");

   a_second_follows_first: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_second |-> $past(cmd.rd_first))
      else $error("second-level read without first-level read");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !(rsp_valid && rsp_stall))
      else $error("result overwrote a stalled beat");

endmodule
